[hdl/rpv_pkg.sv]
package rpv_pkg;

  // Fixed field and register widths.
  localparam int CharW     = 8;
  localparam int ReasonW   = 4;
  localparam int PathRegW  = 13;
  localparam int CompRegW  = 8;
  localparam int DataW     = 32;
  localparam int AddrW     = 3;

  // Default capacity of the path buffer, terminator included.
  localparam int PathBytesMaxDef = 4096;

  // Register reset values.
  localparam logic [PathRegW-1:0] PathLimitRst = 13'd256;
  localparam logic [CompRegW-1:0] CompLimitRst = 8'd64;

  // Register indexes.
  localparam logic RegPathLimit = 1'b0;
  localparam logic RegCompLimit = 1'b1;

  // Character codes.
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChSpace = 8'd32;
  localparam logic [CharW-1:0] ChDel   = 8'd127;
  localparam logic [CharW-1:0] ChColon = 8'h3a;
  localparam logic [CharW-1:0] ChSlash = 8'h2f;
  localparam logic [CharW-1:0] ChBslash = 8'h5c;
  localparam logic [CharW-1:0] ChDot   = 8'h2e;

  // Reason codes.
  localparam logic [ReasonW-1:0] RsnOk        = 4'd0;
  localparam logic [ReasonW-1:0] RsnEmpty     = 4'd1;
  localparam logic [ReasonW-1:0] RsnLead      = 4'd2;
  localparam logic [ReasonW-1:0] RsnBadCh     = 4'd3;
  localparam logic [ReasonW-1:0] RsnEmptyComp = 4'd4;
  localparam logic [ReasonW-1:0] RsnDot       = 4'd5;
  localparam logic [ReasonW-1:0] RsnDotDot    = 4'd6;
  localparam logic [ReasonW-1:0] RsnCompLong  = 4'd7;
  localparam logic [ReasonW-1:0] RsnPathLong  = 4'd8;

  // Component and error state carried from character to character.
  typedef struct packed {
    logic [CompRegW-1:0] clen;
    logic                fdot;
    logic                sdot;
    logic                err;
    logic [ReasonW-1:0]  code;
  } rpv_comp_t;

  // Verdict for a finished path.
  typedef struct packed {
    logic               emit;
    logic               valid_res;
    logic [ReasonW-1:0] reason;
  } rpv_verdict_t;

endpackage

[hdl/rpv_rules.sv]
module rpv_rules #(
  parameter int PosW = 12,
  parameter int LimW = 13
) (
  input  logic [rpv_pkg::CharW-1:0]    ch,
  input  logic [PosW-1:0]              pos,
  input  rpv_pkg::rpv_comp_t           comp,
  input  logic [LimW-1:0]              plim,
  input  logic [rpv_pkg::CompRegW-1:0] clim,
  output logic [PosW-1:0]              pos_nxt,
  output rpv_pkg::rpv_comp_t           comp_nxt,
  output rpv_pkg::rpv_verdict_t        verdict
);

  logic                         is_sep;
  logic                         is_bad;
  logic                         path_full;
  logic                         comp_full;
  logic [rpv_pkg::ReasonW-1:0]  comp_code;
  logic [rpv_pkg::ReasonW-1:0]  term_code;
  logic                         term_err;

  // Character classes and limit checks.
  assign is_sep    = (ch == rpv_pkg::ChSlash) || (ch == rpv_pkg::ChBslash);
  assign is_bad    = (ch < rpv_pkg::ChSpace) || (ch == rpv_pkg::ChDel) ||
                     (ch == rpv_pkg::ChColon);
  assign path_full = ({{(LimW-PosW){1'b0}}, pos} + LimW'(1)) >= plim;
  assign comp_full = ({1'b0, comp.clen} + 9'd1) > {1'b0, clim};

  // How the current component ends.
  always_comb begin
    if (comp.clen == '0) begin
      comp_code = rpv_pkg::RsnEmptyComp;
    end else if ((comp.clen == 8'd1) && comp.fdot) begin
      comp_code = rpv_pkg::RsnDot;
    end else if ((comp.clen == 8'd2) && comp.fdot && comp.sdot) begin
      comp_code = rpv_pkg::RsnDotDot;
    end else begin
      comp_code = rpv_pkg::RsnOk;
    end
  end

  // Final error for the terminator.
  always_comb begin
    term_err  = comp.err;
    term_code = comp.code;
    if (!comp.err) begin
      if (pos == '0) begin
        term_err  = 1'b1;
        term_code = rpv_pkg::RsnEmpty;
      end else if (comp_code != rpv_pkg::RsnOk) begin
        term_err  = 1'b1;
        term_code = comp_code;
      end
    end
  end

  // Rule sequence for one character.
  always_comb begin
    pos_nxt           = pos;
    comp_nxt          = comp;
    verdict.emit      = 1'b0;
    verdict.valid_res = ~term_err;
    verdict.reason    = term_code;
    if (ch == rpv_pkg::ChNul) begin
      verdict.emit = 1'b1;
      pos_nxt      = '0;
      comp_nxt     = '0;
    end else if (comp.err) begin
      // Later characters are ignored once an error is held.
    end else if ((pos == '0) && is_sep) begin
      comp_nxt.err  = 1'b1;
      comp_nxt.code = rpv_pkg::RsnLead;
    end else if (path_full) begin
      comp_nxt.err  = 1'b1;
      comp_nxt.code = rpv_pkg::RsnPathLong;
    end else if (is_bad) begin
      comp_nxt.err  = 1'b1;
      comp_nxt.code = rpv_pkg::RsnBadCh;
    end else if (is_sep) begin
      if (comp_code != rpv_pkg::RsnOk) begin
        comp_nxt.err  = 1'b1;
        comp_nxt.code = comp_code;
      end else begin
        comp_nxt.clen = '0;
        comp_nxt.fdot = 1'b0;
        comp_nxt.sdot = 1'b0;
        pos_nxt       = pos + PosW'(1);
      end
    end else begin
      if (comp.clen == '0) begin
        comp_nxt.fdot = (ch == rpv_pkg::ChDot);
      end else if (comp.clen == 8'd1) begin
        comp_nxt.sdot = (ch == rpv_pkg::ChDot);
      end
      if (comp_full) begin
        comp_nxt.err  = 1'b1;
        comp_nxt.code = rpv_pkg::RsnCompLong;
      end else begin
        comp_nxt.clen = comp.clen + 8'd1;
        pos_nxt       = pos + PosW'(1);
      end
    end
  end

endmodule

[hdl/relative_path_validator_unit.sv]
// Channel | Ports                                                | Transfer
// --------+------------------------------------------------------+---------------------------
// input   | in_valid, in_ready, in_ch                            | one path character
// result  | out_valid, out_ready, out_valid_res, out_reason      | one verdict per terminator
// config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | register write or read
//
// One character is accepted per cycle unless a waiting terminator holds off the input,
// and is held in an input register, where the rule stage judges it; a verdict is loaded
// into the result register when its terminator passes the rule stage.
// The single rule stage updates the path state whenever a held character advances.
// Reset (synchronous, rst_n low) clears the path state and loads the register defaults.
// A terminator waits in the input register only while the result register is full and not
// taken, and the input is held off meanwhile; other characters never wait there.
module relative_path_validator_unit #(
  parameter int PATH_BYTES_MAX = rpv_pkg::PathBytesMaxDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rpv_pkg::CharW-1:0]     in_ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_valid_res,
  output logic [rpv_pkg::ReasonW-1:0]   out_reason,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpv_pkg::AddrW-1:0]     paddr,
  input  logic [rpv_pkg::DataW-1:0]     pwdata,
  output logic [rpv_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  localparam int PosW  = $clog2(PATH_BYTES_MAX);
  localparam int NeedW = $clog2(PATH_BYTES_MAX + 1);
  localparam int LimW  = (NeedW > rpv_pkg::PathRegW) ? NeedW : rpv_pkg::PathRegW;

  logic [rpv_pkg::PathRegW-1:0] path_limit_r;
  logic [rpv_pkg::CompRegW-1:0] comp_limit_r;
  logic [LimW-1:0]              plim_wide;
  logic [LimW-1:0]              plim;
  logic [rpv_pkg::CompRegW-1:0] clim;
  logic                         cfg_wr;

  logic                         ch_vld_r;
  logic [rpv_pkg::CharW-1:0]    ch_r;
  logic                         stage_go;

  logic [PosW-1:0]              pos_r;
  logic [PosW-1:0]              pos_nxt;
  rpv_pkg::rpv_comp_t           comp_r;
  rpv_pkg::rpv_comp_t           comp_nxt;
  rpv_pkg::rpv_verdict_t        verdict;

  logic                         out_vld_r;
  logic                         out_res_r;
  logic [rpv_pkg::ReasonW-1:0]  out_rsn_r;
  logic                         out_free;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_limit_r <= rpv_pkg::PathLimitRst;
      comp_limit_r <= rpv_pkg::CompLimitRst;
    end else if (cfg_wr) begin
      if (paddr[2] == rpv_pkg::RegPathLimit) begin
        path_limit_r <= pwdata[rpv_pkg::PathRegW-1:0];
      end else begin
        comp_limit_r <= pwdata[rpv_pkg::CompRegW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == rpv_pkg::RegPathLimit) begin
      prdata = {{(rpv_pkg::DataW-rpv_pkg::PathRegW){1'b0}}, path_limit_r};
    end else begin
      prdata = {{(rpv_pkg::DataW-rpv_pkg::CompRegW){1'b0}}, comp_limit_r};
    end
  end

  // Effective limits: path limit clamped to the buffer range, component limit at least one.
  assign plim_wide = {{(LimW-rpv_pkg::PathRegW){1'b0}}, path_limit_r};
  always_comb begin
    if (plim_wide < LimW'(2)) begin
      plim = LimW'(2);
    end else if (plim_wide > LimW'(PATH_BYTES_MAX)) begin
      plim = LimW'(PATH_BYTES_MAX);
    end else begin
      plim = plim_wide;
    end
  end
  assign clim = (comp_limit_r == '0) ? 8'd1 : comp_limit_r;

  // Input register; a terminator advances only when the result register can take it.
  assign out_free = !out_vld_r || out_ready;
  assign stage_go = ch_vld_r && ((ch_r != rpv_pkg::ChNul) || out_free);
  assign in_ready = !ch_vld_r || stage_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r <= 1'b0;
    end else if (in_ready) begin
      ch_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= in_ch;
    end
  end

  // Rule stage.
  rpv_rules #(
    .PosW (PosW),
    .LimW (LimW)
  ) u_rules (
    .ch       (ch_r),
    .pos      (pos_r),
    .comp     (comp_r),
    .plim     (plim),
    .clim     (clim),
    .pos_nxt  (pos_nxt),
    .comp_nxt (comp_nxt),
    .verdict  (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      comp_r <= '0;
    end else if (stage_go) begin
      pos_r  <= pos_nxt;
      comp_r <= comp_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (stage_go && verdict.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && verdict.emit) begin
      out_res_r <= verdict.valid_res;
      out_rsn_r <= verdict.reason;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_valid_res = out_res_r;
  assign out_reason    = out_rsn_r;

`ifndef SYNTHESIS
  // The error flag and a non-zero reason always travel together.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r.err == (comp_r.code != rpv_pkg::RsnOk))
    else $error("error flag and reason code disagree");

  // A delivered pass carries reason zero and a fail carries a reason.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_valid_res == (out_reason == rpv_pkg::RsnOk)))
    else $error("verdict and reason disagree");

  // Input stalls only behind a terminator waiting for a full result register.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (ch_vld_r && (ch_r == rpv_pkg::ChNul) && out_valid && !out_ready))
    else $error("input stalled without cause");

  // A verdict leaves the path state cleared.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_go && verdict.emit) |=> ((pos_r == '0) && (comp_r == '0)))
    else $error("path state not cleared after verdict");
`endif

endmodule
